// ===== rtl/afr_pkg.sv =====
package afr_pkg;

  localparam int BYTE_W    = 8;
  localparam int CRC_W     = 16;
  localparam int NBITS_W   = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  localparam logic [CFG_IDX_W-1:0] REG_CRC_POLY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_CHAR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_CHAR = 2'd2;

  localparam logic [CRC_W-1:0]  CRC_POLY_RST   = 16'h1021;
  localparam logic [BYTE_W-1:0] SYNC_CHAR_RST  = 8'h16;
  localparam logic [BYTE_W-1:0] START_CHAR_RST = 8'h01;

  localparam logic [BYTE_W-1:0] PREAMBLE_BYTE = 8'hFF;
  localparam logic [BYTE_W-1:0] HDR1_CHAR     = 8'hAB;
  localparam logic [BYTE_W-1:0] HDR2_CHAR     = 8'h2A;
  localparam logic [6:0]        ETX_CHAR      = 7'h03;
  localparam logic [6:0]        ETB_CHAR      = 7'h17;
  localparam logic [6:0]        CR_CHAR       = 7'h0D;
  localparam logic [6:0]        LF_CHAR       = 7'h0A;
  localparam logic [6:0]        CTRL_LIMIT    = 7'h20;
  localparam logic [BYTE_W-1:0] SUBST_CHAR    = 8'hA4;

  localparam logic [NBITS_W-1:0] NB_FULL     = 4'd8;
  localparam logic [NBITS_W-1:0] NB_PREAMBLE = 4'd6;
  localparam logic [NBITS_W-1:0] NB_SLIP_OFS = 4'd2;

  localparam logic [BYTE_W-1:0] SYNC_ERR_LIMIT = 8'd2;

endpackage

// ===== rtl/afr_crc.sv =====
module afr_crc (
  input  logic [afr_pkg::CRC_W-1:0]  crc_in,
  input  logic [afr_pkg::BYTE_W-1:0] data,
  input  logic [afr_pkg::CRC_W-1:0]  poly,
  output logic [afr_pkg::CRC_W-1:0]  crc_out
);
  import afr_pkg::*;

  logic [CRC_W-1:0] c;
  logic             top;

  always_comb begin
    c   = crc_in;
    top = 1'b0;
    for (int k = 0; k < BYTE_W; k++) begin
      top = c[CRC_W-1];
      c   = {c[CRC_W-2:0], data[k]};
      if (top) begin
        c = c ^ poly;
      end
    end
    crc_out = c;
  end

endmodule

// ===== rtl/acars_frame_receiver_top.sv =====
// ACARS frame receiver: takes one demodulated byte per word and returns exactly one result
// word per byte, carrying the bit count to gather next, a polarity clear request, a
// sanitized text character and the end-of-frame verdict. A new byte is taken every cycle
// while the output is free or being taken; each byte passes an input register, one pass of
// frame state logic with an eight-step unrolled CRC-16 update, and a result register, from
// which the result word is offered. The user must write configuration registers through
// the plain write port only while no byte is in flight; the block does not enforce this.
module acars_frame_receiver_top #(
  parameter int MAX_TEXT = 243
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [afr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [afr_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [afr_pkg::BYTE_W-1:0]    rx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [afr_pkg::NBITS_W-1:0]   next_bits,
  output logic                          clear_polarity,
  output logic                          char_valid,
  output logic [afr_pkg::BYTE_W-1:0]    text_char,
  output logic                          frame_end,
  output logic                          frame_good,
  output logic [afr_pkg::BYTE_W-1:0]    text_length
);
  import afr_pkg::*;

  typedef enum logic [3:0] {
    PH_HUNT = 4'd0,
    PH_PRE  = 4'd1,
    PH_HDR1 = 4'd2,
    PH_HDR2 = 4'd3,
    PH_SYN1 = 4'd4,
    PH_SYN2 = 4'd5,
    PH_SOH  = 4'd6,
    PH_TEXT = 4'd7,
    PH_CRC1 = 4'd8,
    PH_CRC2 = 4'd9,
    PH_END  = 4'd10
  } phase_t;

  logic [CRC_W-1:0]  crc_poly;
  logic [BYTE_W-1:0] sync_char;
  logic [BYTE_W-1:0] start_char;

  phase_t            phase, phase_next;
  logic [BYTE_W-1:0] char_count, char_count_next;
  logic [CRC_W-1:0]  crc_residue, crc_residue_next;
  logic [CRC_W-1:0]  crc_fed;

  logic              in_full;
  logic [BYTE_W-1:0] in_byte;
  logic              advance;

  logic [NBITS_W-1:0] nb;
  logic               clr, cv, fe, fg;
  logic [BYTE_W-1:0]  tc, tl, cnt_inc;
  logic [2:0]         ones;
  logic               run;
  logic [6:0]         rm;
  logic [BYTE_W:0]    n;

  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  afr_crc u_crc (
    .crc_in  (crc_residue),
    .data    (in_byte),
    .poly    (crc_poly),
    .crc_out (crc_fed)
  );

  always_comb begin
    ones = '0;
    run  = 1'b1;
    for (int k = 0; k < 7; k++) begin
      if (run && in_byte[k]) begin
        ones = ones + 3'd1;
      end else begin
        run = 1'b0;
      end
    end
  end

  always_comb begin
    phase_next       = phase;
    char_count_next  = char_count;
    crc_residue_next = crc_residue;
    nb      = NB_FULL;
    clr     = 1'b0;
    cv      = 1'b0;
    tc      = '0;
    fe      = 1'b0;
    fg      = 1'b0;
    tl      = '0;
    cnt_inc = char_count;
    rm      = in_byte[6:0];
    n       = {1'b0, char_count} + {{BYTE_W{1'b0}}, 1'b1};
    case (phase)
      PH_PRE: begin
        if (in_byte == PREAMBLE_BYTE) begin
          nb = NB_PREAMBLE;
        end else if (ones < 3'd2) begin
          phase_next = PH_HUNT;
          clr        = 1'b1;
        end else if (ones == 3'd2) begin
          phase_next      = PH_HDR2;
          char_count_next = (in_byte != HDR1_CHAR) ? 8'd1 : 8'd0;
        end else begin
          phase_next      = PH_HDR1;
          char_count_next = '0;
          nb              = {1'b0, ones} - NB_SLIP_OFS;
        end
      end
      PH_HDR1: begin
        char_count_next = char_count + {7'd0, in_byte != HDR1_CHAR};
        phase_next      = PH_HDR2;
      end
      PH_HDR2: begin
        char_count_next = char_count + {7'd0, in_byte != HDR2_CHAR};
        phase_next      = PH_SYN1;
      end
      PH_SYN1: begin
        char_count_next = char_count + {7'd0, in_byte != sync_char};
        phase_next      = PH_SYN2;
      end
      PH_SYN2: begin
        char_count_next = char_count + {7'd0, in_byte != sync_char};
        phase_next      = PH_SOH;
      end
      PH_SOH: begin
        cnt_inc = char_count + {7'd0, in_byte != start_char};
        if (cnt_inc > SYNC_ERR_LIMIT) begin
          char_count_next = cnt_inc;
          if (in_byte == PREAMBLE_BYTE) begin
            phase_next = PH_PRE;
          end else begin
            phase_next = PH_HUNT;
            clr        = 1'b1;
          end
        end else begin
          phase_next       = PH_TEXT;
          char_count_next  = '0;
          crc_residue_next = '0;
        end
      end
      PH_TEXT: begin
        crc_residue_next = crc_fed;
        if (rm == ETX_CHAR || rm == ETB_CHAR) begin
          phase_next = PH_CRC1;
        end else begin
          cv = 1'b1;
          if (rm < CTRL_LIMIT && rm != CR_CHAR && rm != LF_CHAR) begin
            tc = SUBST_CHAR;
          end else begin
            tc = {1'b0, rm};
          end
          char_count_next = n[BYTE_W-1:0];
          if (n > (BYTE_W+1)'(MAX_TEXT)) begin
            fe         = 1'b1;
            tl         = n[BYTE_W] ? {BYTE_W{1'b1}} : n[BYTE_W-1:0];
            phase_next = PH_HUNT;
            clr        = 1'b1;
          end
        end
      end
      PH_CRC1: begin
        crc_residue_next = crc_fed;
        phase_next       = PH_CRC2;
      end
      PH_CRC2: begin
        crc_residue_next = crc_fed;
        phase_next       = PH_END;
      end
      PH_END: begin
        phase_next = PH_HUNT;
        fe         = 1'b1;
        fg         = (crc_residue == '0);
        tl         = char_count;
      end
      default: begin
        if (in_byte == PREAMBLE_BYTE) begin
          phase_next = PH_PRE;
        end else begin
          phase_next = PH_HUNT;
          clr        = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_poly    <= CRC_POLY_RST;
      sync_char   <= SYNC_CHAR_RST;
      start_char  <= START_CHAR_RST;
      phase       <= PH_HUNT;
      char_count  <= '0;
      crc_residue <= '0;
      in_full     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CRC_POLY:   crc_poly   <= cfg_data[CRC_W-1:0];
          REG_SYNC_CHAR:  sync_char  <= cfg_data[BYTE_W-1:0];
          REG_START_CHAR: start_char <= cfg_data[BYTE_W-1:0];
          default: ;
        endcase
      end
      if (in_ready) begin
        in_full <= in_valid;
      end
      if (advance) begin
        phase       <= phase_next;
        char_count  <= char_count_next;
        crc_residue <= crc_residue_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte <= rx_byte;
    end
    if (advance) begin
      next_bits      <= nb;
      clear_polarity <= clr;
      char_valid     <= cv;
      text_char      <= tc;
      frame_end      <= fe;
      frame_good     <= fg;
      text_length    <= tl;
    end
  end

  a_good_needs_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_good |-> frame_end)
    else $error("frame_good without frame_end");

  a_char_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !char_valid |-> text_char == '0)
    else $error("text_char set without char_valid");

  a_len_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_end |-> text_length == '0)
    else $error("text_length set without frame_end");

  a_nbits_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> next_bits != '0 && next_bits <= NB_FULL)
    else $error("next_bits out of range");

endmodule

// ===== tb/sv/acars_frame_receiver_top_test.sv =====
module acars_frame_receiver_top_test;
  import afr_pkg::*;

  localparam int TEXT_LIMIT = 243;
  localparam int HOLD_CYCLES = 120;
  localparam int STUCK_LIMIT = 2000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef enum logic [3:0] {
    PH_HUNT, PH_PRE, PH_HDR1, PH_HDR2, PH_SYN1, PH_SYN2, PH_SOH,
    PH_TEXT, PH_CRC1, PH_CRC2, PH_END
  } afr_phase_t;

  typedef struct packed {
    logic [NBITS_W-1:0] next_bits;
    logic               clear_polarity;
    logic               char_valid;
    logic [BYTE_W-1:0]  text_char;
    logic               frame_end;
    logic               frame_good;
    logic [BYTE_W-1:0]  text_length;
  } afr_word_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [BYTE_W-1:0]    rx_byte = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [NBITS_W-1:0]   next_bits;
  logic                 clear_polarity;
  logic                 char_valid;
  logic [BYTE_W-1:0]    text_char;
  logic                 frame_end;
  logic                 frame_good;
  logic [BYTE_W-1:0]    text_length;

  afr_phase_t        rx_phase = PH_HUNT;
  logic [BYTE_W-1:0] tally = '0;
  logic [CRC_W-1:0]  residue = '0;
  logic [CRC_W-1:0]  poly_reg = CRC_POLY_RST;
  logic [BYTE_W-1:0] sync_reg = SYNC_CHAR_RST;
  logic [BYTE_W-1:0] soh_reg = START_CHAR_RST;

  afr_word_t pending_words[$];
  int        mismatch_count = 0;
  int        stuck_cycles = 0;
  int        tx_gap_max = 0;
  int        rx_stall_max = 0;
  bit        hold_req = 1'b0;

  acars_frame_receiver_top #(
    .MAX_TEXT(TEXT_LIMIT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .next_bits(next_bits),
    .clear_polarity(clear_polarity),
    .char_valid(char_valid),
    .text_char(text_char),
    .frame_end(frame_end),
    .frame_good(frame_good),
    .text_length(text_length)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [CRC_W-1:0] crc_shift8(input logic [CRC_W-1:0] acc,
                                                  input logic [BYTE_W-1:0] b);
    logic msb;
    int   k;
    for (k = 0; k < 8; k++) begin
      msb = acc[15];
      acc = {acc[14:0], b[k]};
      if (msb) acc = acc ^ poly_reg;
    end
    return acc;
  endfunction

  // two bytes that bring the residue to zero, first byte in the upper half
  function automatic logic [CRC_W-1:0] crc_closing(input logic [CRC_W-1:0] acc);
    logic [CRC_W-1:0] rem;
    logic [CRC_W-1:0] bytes_out;
    int               j;
    rem = crc_shift8(crc_shift8(acc, 8'h00), 8'h00);
    for (j = 0; j < 8; j++) begin
      bytes_out[8 + j] = rem[15 - j];
      bytes_out[j] = rem[7 - j];
    end
    return bytes_out;
  endfunction

  function automatic afr_word_t decode_byte(input logic [BYTE_W-1:0] in_byte);
    afr_word_t         w;
    logic [BYTE_W-1:0] r;
    logic [BYTE_W-1:0] sym;
    logic              again;
    int                pass;
    int                ones;
    int                n;
    w = '0;
    w.next_bits = NB_FULL;
    r = in_byte;
    again = 1'b1;
    for (pass = 0; pass < 3 && again; pass++) begin
      again = 1'b0;
      case (rx_phase)
        PH_PRE: begin
          if (r == PREAMBLE_BYTE) begin
            w.next_bits = NB_PREAMBLE;
          end else begin
            ones = 0;
            while (ones < 7 && r[ones]) ones++;
            if (ones < 2) begin
              rx_phase = PH_HUNT;
              again = 1'b1;
            end else begin
              rx_phase = PH_HDR1;
              tally = '0;
              if (ones == 2) again = 1'b1;
              else w.next_bits = NBITS_W'(ones) - NB_SLIP_OFS;
            end
          end
        end
        PH_HDR1: begin
          if (r != HDR1_CHAR) tally++;
          rx_phase = PH_HDR2;
        end
        PH_HDR2: begin
          if (r != HDR2_CHAR) tally++;
          rx_phase = PH_SYN1;
        end
        PH_SYN1: begin
          if (r != sync_reg) tally++;
          rx_phase = PH_SYN2;
        end
        PH_SYN2: begin
          if (r != sync_reg) tally++;
          rx_phase = PH_SOH;
        end
        PH_SOH: begin
          if (r != soh_reg) tally++;
          if (tally > SYNC_ERR_LIMIT) begin
            rx_phase = PH_HUNT;
            again = 1'b1;
          end else begin
            rx_phase = PH_TEXT;
            tally = '0;
            residue = '0;
          end
        end
        PH_TEXT: begin
          residue = crc_shift8(residue, r);
          r = {1'b0, r[6:0]};
          if (r[6:0] == ETX_CHAR || r[6:0] == ETB_CHAR) begin
            rx_phase = PH_CRC1;
          end else begin
            sym = r;
            if (r[6:0] < CTRL_LIMIT && r[6:0] != CR_CHAR && r[6:0] != LF_CHAR) begin
              sym = SUBST_CHAR;
            end
            w.char_valid = 1'b1;
            w.text_char = sym;
            n = int'(tally) + 1;
            tally = n[7:0];
            if (n > TEXT_LIMIT) begin
              w.frame_end = 1'b1;
              w.frame_good = 1'b0;
              w.text_length = (n > 255) ? 8'hFF : n[7:0];
              rx_phase = PH_HUNT;
              again = 1'b1;
            end
          end
        end
        PH_CRC1: begin
          residue = crc_shift8(residue, r);
          rx_phase = PH_CRC2;
        end
        PH_CRC2: begin
          residue = crc_shift8(residue, r);
          rx_phase = PH_END;
        end
        PH_END: begin
          rx_phase = PH_HUNT;
          w.frame_end = 1'b1;
          w.frame_good = (residue == '0);
          w.text_length = tally;
        end
        default: begin
          if (r == PREAMBLE_BYTE) begin
            rx_phase = PH_PRE;
          end else begin
            rx_phase = PH_HUNT;
            w.clear_polarity = 1'b1;
          end
        end
      endcase
    end
    return w;
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    pending_words.push_back(decode_byte(b));
  endtask

  task automatic wait_all_words();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_CRC_POLY) poly_reg = val;
    else if (idx == REG_SYNC_CHAR) sync_reg = val[7:0];
    else if (idx == REG_START_CHAR) soh_reg = val[7:0];
  endtask

  task automatic send_frame(input int pre_n, input int slip_ones, input int n_err,
                            input int text_len, input bit crc_ok, input bit use_etb);
    logic [BYTE_W-1:0] want [5];
    logic [BYTE_W-1:0] b;
    logic [CRC_W-1:0]  acc;
    logic [CRC_W-1:0]  tail;
    int                i;
    int                k;
    int                left;
    want[0] = HDR1_CHAR;
    want[1] = HDR2_CHAR;
    want[2] = sync_reg;
    want[3] = sync_reg;
    want[4] = soh_reg;
    // terminate whatever is in progress
    while (rx_phase != PH_HUNT) send_byte({1'b0, ETX_CHAR});
    for (i = 0; i < pre_n; i++) send_byte(PREAMBLE_BYTE);
    if (slip_ones > 2) begin
      b = 8'($urandom);
      for (k = 0; k < slip_ones; k++) b[k] = 1'b1;
      b[slip_ones] = 1'b0;
      send_byte(b);
    end
    left = n_err;
    for (i = 0; i < 5; i++) begin
      b = want[i];
      if (left > 0 && $urandom_range(1, 5 - i) <= left) begin
        left--;
        do begin
          b = 8'($urandom);
          if (i == 0 && slip_ones == 2) b[2:0] = 3'b011;
        end while (b == want[i]);
      end
      send_byte(b);
    end
    acc = '0;
    for (i = 0; i < text_len && rx_phase == PH_TEXT; i++) begin
      do begin
        b = 8'($urandom);
        if ($urandom_range(0, 3) == 0) b[6:5] = 2'b00;
      end while (b[6:0] == ETX_CHAR || b[6:0] == ETB_CHAR);
      acc = crc_shift8(acc, b);
      send_byte(b);
    end
    if (rx_phase == PH_TEXT) begin
      b = {1'($urandom_range(0, 1)), use_etb ? ETB_CHAR : ETX_CHAR};
      acc = crc_shift8(acc, b);
      send_byte(b);
      tail = crc_closing(acc);
      if (!crc_ok) tail[$urandom_range(0, 15)] ^= 1'b1;
      send_byte(tail[15:8]);
      send_byte(tail[7:0]);
      send_byte(8'($urandom));
    end
  endtask

  task automatic random_frame(input int max_len);
    send_frame($urandom_range(1, 3), $urandom_range(2, 7),
               ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0,
               $urandom_range(0, max_len), $urandom_range(0, 7) != 0,
               $urandom_range(0, 1) == 1);
  endtask

  task automatic test_directed();
    logic [BYTE_W-1:0] txt [5];
    logic [CRC_W-1:0]  acc;
    logic [CRC_W-1:0]  tail;
    int                i;
    tx_gap_max = 0;
    rx_stall_max = 0;
    txt = '{8'h00, 8'h8D, 8'h0A, 8'hFF, 8'h20};
    send_byte(PREAMBLE_BYTE);
    send_byte(8'h00);
    send_byte(PREAMBLE_BYTE);
    send_byte(8'hFD);
    send_byte(PREAMBLE_BYTE);
    send_byte(PREAMBLE_BYTE);
    send_byte(HDR1_CHAR);
    send_byte(8'h00);
    send_byte(sync_reg);
    send_byte(8'h00);
    send_byte(soh_reg);
    acc = '0;
    for (i = 0; i < 5; i++) begin
      acc = crc_shift8(acc, txt[i]);
      send_byte(txt[i]);
    end
    acc = crc_shift8(acc, {1'b1, ETB_CHAR});
    send_byte({1'b1, ETB_CHAR});
    tail = crc_closing(acc);
    send_byte(tail[15:8]);
    send_byte(tail[7:0]);
    send_byte(8'h00);
    // three header mismatches after a seven-ones slip
    send_byte(PREAMBLE_BYTE);
    send_byte(8'h7F);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(sync_reg);
    send_byte(soh_reg);
    wait_all_words();
  endtask

  task automatic test_random_frames();
    int f;
    tx_gap_max = 16;
    rx_stall_max = 16;
    for (f = 0; f < 8; f++) random_frame(10);
    wait_all_words();
  endtask

  task automatic test_config_sweep();
    int s;
    int f;
    tx_gap_max = 4;
    rx_stall_max = 16;
    for (s = 0; s < 4; s++) begin
      case (s)
        0: begin
          write_cfg(REG_CRC_POLY, 16'h0000);
          write_cfg(REG_SYNC_CHAR, 16'h0000);
          write_cfg(REG_START_CHAR, 16'h0000);
        end
        1: begin
          write_cfg(REG_CRC_POLY, 16'hFFFF);
          write_cfg(REG_SYNC_CHAR, 16'hFFFF);
          write_cfg(REG_START_CHAR, 16'hFFFF);
        end
        2: begin
          write_cfg(REG_CRC_POLY, 16'($urandom));
          write_cfg(REG_SYNC_CHAR, 16'($urandom));
          write_cfg(REG_START_CHAR, 16'($urandom));
          write_cfg(REG_SPARE, 16'($urandom));
        end
        default: begin
          write_cfg(REG_CRC_POLY, CRC_POLY_RST);
          write_cfg(REG_SYNC_CHAR, {8'($urandom), SYNC_CHAR_RST});
          write_cfg(REG_START_CHAR, {8'($urandom), START_CHAR_RST});
        end
      endcase
      for (f = 0; f < 2; f++) random_frame(10);
      wait_all_words();
    end
  endtask

  task automatic test_noise();
    logic [BYTE_W-1:0] b;
    int                i;
    tx_gap_max = 16;
    rx_stall_max = 0;
    for (i = 0; i < 40; i++) begin
      case ($urandom_range(0, 4))
        0: b = PREAMBLE_BYTE;
        1: b = HDR1_CHAR;
        2: b = {1'($urandom_range(0, 1)), ETX_CHAR};
        default: b = 8'($urandom);
      endcase
      send_byte(b);
    end
    random_frame(10);
    wait_all_words();
  endtask

  task automatic test_output_hold();
    tx_gap_max = 0;
    rx_stall_max = 0;
    hold_req = 1'b1;
    random_frame(12);
    random_frame(12);
    wait_all_words();
  endtask

  task automatic test_overflow();
    tx_gap_max = 1;
    rx_stall_max = 1;
    send_frame(2, 4, 1, TEXT_LIMIT + 1, 1'b1, 1'b0);
    random_frame(6);
    wait_all_words();
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  initial begin : word_sink
    int stall;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      stall = $urandom_range(0, rx_stall_max);
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : word_check
    afr_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        $display("%0t: word with none expected, actual next_bits %0h text_char %0h",
                 $time, next_bits, text_char);
        mismatch_count++;
      end else begin
        want = pending_words.pop_front();
        check_field("next_bits", 16'(want.next_bits), 16'(next_bits));
        check_field("clear_polarity", 16'(want.clear_polarity), 16'(clear_polarity));
        check_field("char_valid", 16'(want.char_valid), 16'(char_valid));
        check_field("text_char", 16'(want.text_char), 16'(text_char));
        check_field("frame_end", 16'(want.frame_end), 16'(frame_end));
        check_field("frame_good", 16'(want.frame_good), 16'(frame_good));
        check_field("text_length", 16'(want.text_length), 16'(text_length));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("acars_frame_receiver_top verification failed");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_frames();
    test_config_sweep();
    test_noise();
    test_output_hold();
    test_overflow();
    wait_all_words();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("acars_frame_receiver_top verification clean");
    end else begin
      $display("acars_frame_receiver_top verification failed");
    end
    $finish;
  end

endmodule
